[rtl/core/positional_ordered_list_assert.svh]
// Assertion macros shared by the positional ordered list RTL.
`ifndef POSITIONAL_ORDERED_LIST_ASSERT_SVH
`define POSITIONAL_ORDERED_LIST_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define POL_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define POL_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

[rtl/core/pol_pkg.sv]
// Types, codes and constants of the positional ordered list.
`timescale 1ns / 1ps

package pol_pkg;

	localparam int CW = 5;          // entry count and position width
	localparam int WW = 32;         // word width
	localparam int QDEPTH = 2;      // command queue depth
	localparam int QAW = $clog2(QDEPTH);
	localparam int QCW = $clog2(QDEPTH + 1);

	typedef logic signed [WW-1:0] word_t;

	// request function codes
	localparam logic [2:0] FN_INS_FRONT = 3'd0;
	localparam logic [2:0] FN_INS_BACK  = 3'd1;
	localparam logic [2:0] FN_INS_POS   = 3'd2;
	localparam logic [2:0] FN_REM_FRONT = 3'd3;
	localparam logic [2:0] FN_REM_BACK  = 3'd4;
	localparam logic [2:0] FN_REM_POS   = 3'd5;
	localparam logic [2:0] FN_SEARCH    = 3'd6;

	// result status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;
	localparam logic [1:0] ST_FULL  = 2'd3;

	// decoded command kind
	localparam logic [1:0] KIND_NOP  = 2'd0;
	localparam logic [1:0] KIND_INS  = 2'd1;
	localparam logic [1:0] KIND_REM  = 2'd2;
	localparam logic [1:0] KIND_SRCH = 2'd3;

	// decoded command place
	localparam logic [1:0] AT_FRONT = 2'd0;
	localparam logic [1:0] AT_BACK  = 2'd1;
	localparam logic [1:0] AT_POS   = 2'd2;

	typedef struct packed {
		logic [2:0]    func;
		word_t         value;
		logic [CW-1:0] position;
	} req_t;

	typedef struct packed {
		logic [1:0]    status;
		logic          found;
		logic [CW-1:0] count;
	} res_t;

	typedef struct packed {
		logic [1:0]    kind;
		logic [1:0]    at;
		word_t         value;
		logic [CW-1:0] position;
	} cmd_t;

endpackage

[rtl/core/pol_front.sv]
// Front end: takes requests and decodes them into queue commands.
`timescale 1ns / 1ps

module pol_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  pol_pkg::req_t request,
	input  logic          q_full,
	output logic          busy,
	output logic          push,
	output pol_pkg::cmd_t cmd
);
	import pol_pkg::*;

	logic vld_s1;
	cmd_t cmd_s1;
	cmd_t dec;
	logic take;

	assign busy = vld_s1 && q_full;
	assign push = vld_s1 && !q_full;
	assign take = start && !busy;
	assign cmd  = cmd_s1;

	// classify the function code
	always_comb begin
		dec.value    = request.value;
		dec.position = request.position;
		dec.kind     = KIND_NOP;
		dec.at       = AT_FRONT;
		case (request.func)
			FN_INS_FRONT: begin
				dec.kind = KIND_INS;
				dec.at   = AT_FRONT;
			end
			FN_INS_BACK: begin
				dec.kind = KIND_INS;
				dec.at   = AT_BACK;
			end
			FN_INS_POS: begin
				dec.kind = KIND_INS;
				dec.at   = AT_POS;
			end
			FN_REM_FRONT: begin
				dec.kind = KIND_REM;
				dec.at   = AT_FRONT;
			end
			FN_REM_BACK: begin
				dec.kind = KIND_REM;
				dec.at   = AT_BACK;
			end
			FN_REM_POS: begin
				dec.kind = KIND_REM;
				dec.at   = AT_POS;
			end
			FN_SEARCH: begin
				dec.kind = KIND_SRCH;
			end
			default: begin
				dec.kind = KIND_NOP;
			end
		endcase
	end

	// holding stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (take) begin
			vld_s1 <= 1'b1;
		end else if (push) begin
			vld_s1 <= 1'b0;
		end
	end

	// holding stage payload
	always_ff @(posedge clk) begin
		if (take) begin
			cmd_s1 <= dec;
		end
	end

endmodule

[rtl/core/pol_queue.sv]
// Short command queue between the front end and the list engine.
`timescale 1ns / 1ps

module pol_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  pol_pkg::cmd_t cmd_in,
	input  logic          pop,
	output logic          full,
	output logic          empty,
	output pol_pkg::cmd_t cmd_out
);
	import pol_pkg::*;

	cmd_t           ent_q [QDEPTH];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QCW-1:0] cnt_q;
	logic           do_pop;

	assign full    = (cnt_q == QCW'(QDEPTH));
	assign empty   = (cnt_q == '0);
	assign do_pop  = pop && !empty;
	assign cmd_out = ent_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push && !full) begin
			ent_q[wr_ptr_q] <= cmd_in;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push && !full) begin
				wr_ptr_q <= (wr_ptr_q == QAW'(QDEPTH - 1)) ? '0 : wr_ptr_q + QAW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QAW'(QDEPTH - 1)) ? '0 : rd_ptr_q + QAW'(1);
			end
			if ((push && !full) && !do_pop) begin
				cnt_q <= cnt_q + QCW'(1);
			end else if (do_pop && !(push && !full)) begin
				cnt_q <= cnt_q - QCW'(1);
			end
		end
	end

`include "positional_ordered_list_assert.svh"

	`POL_ASSERT_IMP(a_no_push_full, clk, arst_n, full, !push)
	`POL_ASSERT_IMP(a_cnt_bound, clk, arst_n, 1'b1, cnt_q <= QCW'(QDEPTH))
	`POL_ASSERT_NXT(a_empty_drain, clk, arst_n, empty && !push, empty)

endmodule

[rtl/core/pol_back.sv]
// List engine: shifting slot cells, entry count and result register.
`timescale 1ns / 1ps

module pol_back #(
	parameter int CAPACITY = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_vld,
	input  pol_pkg::cmd_t cmd,
	output logic          done,
	output pol_pkg::res_t result
);
	import pol_pkg::*;

	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

	word_t          slots_q [CAPACITY];
	logic [CW-1:0]  count_q;
	logic           done_q;
	res_t           res_q;

	logic [CAPACITY-1:0] match;
	logic [CW-1:0]       k;
	logic                do_ins;
	logic                do_rem;
	logic [1:0]          status;
	logic                found;
	logic [CW-1:0]       count_nxt;
	logic [CW:0]         pos_w;
	logic [CW:0]         count_w;

	assign pos_w   = {1'b0, cmd.position};
	assign count_w = {1'b0, count_q};

	// per-cell compare against the search word
	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			match[i] = (CW'(i) < count_q) && (slots_q[i] == cmd.value);
		end
	end

	// status, target index and operation select
	always_comb begin
		status = ST_OK;
		found  = 1'b0;
		do_ins = 1'b0;
		do_rem = 1'b0;
		k      = '0;
		case (cmd.kind)
			KIND_INS: begin
				if (count_q >= CAP_C) begin
					status = ST_FULL;
				end else begin
					case (cmd.at)
						AT_FRONT: begin
							do_ins = 1'b1;
						end
						AT_BACK: begin
							do_ins = 1'b1;
							k      = count_q;
						end
						default: begin
							if (cmd.position == '0 || pos_w > count_w + (CW+1)'(1)) begin
								status = ST_RANGE;
							end else begin
								do_ins = 1'b1;
								k      = cmd.position - CW'(1);
							end
						end
					endcase
				end
			end
			KIND_REM: begin
				if (count_q == '0) begin
					status = ST_EMPTY;
				end else begin
					case (cmd.at)
						AT_FRONT: begin
							do_rem = 1'b1;
						end
						AT_BACK: begin
							do_rem = 1'b1;
							k      = count_q - CW'(1);
						end
						default: begin
							if (cmd.position == '0 || cmd.position > count_q) begin
								status = ST_RANGE;
							end else begin
								do_rem = 1'b1;
								k      = cmd.position - CW'(1);
							end
						end
					endcase
				end
			end
			KIND_SRCH: begin
				if (count_q == '0) begin
					status = ST_EMPTY;
				end else begin
					found = |match;
				end
			end
			default: begin
				status = ST_OK;
			end
		endcase
	end

	always_comb begin
		count_nxt = count_q;
		if (do_ins) begin
			count_nxt = count_q + CW'(1);
		end else if (do_rem) begin
			count_nxt = count_q - CW'(1);
		end
	end

	// slot cells: shift up on insert, down on remove
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		localparam logic [CW-1:0] IDX = CW'(i);
		if (i == 0) begin : g_first
			always_ff @(posedge clk) begin
				if (cmd_vld && do_ins && IDX == k) begin
					slots_q[i] <= cmd.value;
				end else if (cmd_vld && do_rem && IDX >= k) begin
					slots_q[i] <= slots_q[i+1];
				end
			end
		end else if (i == CAPACITY - 1) begin : g_last
			always_ff @(posedge clk) begin
				if (cmd_vld && do_ins && IDX >= k) begin
					slots_q[i] <= (IDX == k) ? cmd.value : slots_q[i-1];
				end
			end
		end else begin : g_mid
			always_ff @(posedge clk) begin
				if (cmd_vld && do_ins && IDX >= k) begin
					slots_q[i] <= (IDX == k) ? cmd.value : slots_q[i-1];
				end else if (cmd_vld && do_rem && IDX >= k) begin
					slots_q[i] <= slots_q[i+1];
				end
			end
		end
	end

	// entry count and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= cmd_vld;
			if (cmd_vld) begin
				count_q <= count_nxt;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (cmd_vld) begin
			res_q.status <= status;
			res_q.found  <= found;
			res_q.count  <= count_nxt;
		end
	end

	assign done   = done_q;
	assign result = res_q;

`include "positional_ordered_list_assert.svh"

	`POL_ASSERT_IMP(a_count_bound, clk, arst_n, 1'b1, count_q <= CAP_C)
	`POL_ASSERT_NXT(a_done_follows, clk, arst_n, cmd_vld, done)
	`POL_ASSERT_IMP(a_full_count, clk, arst_n, done && result.status == ST_FULL, result.count == CAP_C)
	`POL_ASSERT_IMP(a_found_ok, clk, arst_n, done && result.found, result.status == ST_OK)

endmodule

[rtl/core/positional_ordered_list.sv]
// Top level of the positional ordered list: front end, command queue, list engine.
//
//  channel   direction  handshake            payload
//  request   in         start & !busy        request (func, value, position)
//  result    out        done, one cycle      result (status, found, count)
//
// A transaction enters the front holding stage, moves to a two-entry command
// queue and is executed by the list engine, one per cycle. It is registered in
// the holding stage, a queue entry and the result register, raising done; one
// result per cycle is sustained. busy rises only when the holding stage and
// queue are full, which cannot happen: the engine drains one command per cycle.
// arst_n clears all control state and the entry count; slot contents need none.
// The receiver cannot stall: done marks each result for exactly one cycle.
`timescale 1ns / 1ps

module positional_ordered_list #(
	parameter int CAPACITY = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  pol_pkg::req_t request,
	output logic          done,
	output pol_pkg::res_t result
);
	import pol_pkg::*;

	logic push;
	logic q_full;
	logic q_empty;
	cmd_t f_cmd;
	cmd_t q_cmd;

	pol_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.request (request),
		.q_full  (q_full),
		.busy    (busy),
		.push    (push),
		.cmd     (f_cmd)
	);

	pol_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.cmd_in  (f_cmd),
		.pop     (!q_empty),
		.full    (q_full),
		.empty   (q_empty),
		.cmd_out (q_cmd)
	);

	pol_back #(
		.CAPACITY (CAPACITY)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd_vld (!q_empty),
		.cmd     (q_cmd),
		.done    (done),
		.result  (result)
	);

endmodule
